/* rtl/apt_pkg.sv */
`default_nettype none

package apt_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned PROD_W        = 2 * DATA_W;
  localparam int unsigned ACC_W         = PROD_W + 2;
  localparam int unsigned ROWS          = 3;
  localparam int unsigned CELLS         = 4;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_XFORM = 1'b1;

  localparam logic [1:0] ROW_UNUSED = 2'd3;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic                        valid;
    logic                        req_type;
    logic [IDX_W-1:0]            element_index;
    logic [DATA_W-1:0]           element_value;
    logic [ROWS-1:0][DATA_W-1:0] pt;
    logic [ROWS-1:0][ACC_W-1:0]  acc;
  } word_t;

endpackage

`default_nettype wire

/* rtl/apt_cell.sv */
`default_nettype none

module apt_cell import apt_pkg::*; #(
  parameter int unsigned COL       = 0,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire word_t word_i,
  output word_t      word_o
);

  localparam logic [DATA_W-1:0] ONE = DATA_W'(64'(1) << FRAC_BITS);

  word_t                        w_q;
  logic [ROWS-1:0][DATA_W-1:0]  col_q;
  logic signed [PROD_W-1:0]     prod_q [ROWS];
  logic signed [PROD_W-1:0]     prod_d [ROWS];
  logic [DATA_W-1:0]            coord;
  logic                         wr;

  // the bias column multiplies by one
  if (COL < ROWS) begin : g_point
    assign coord = word_i.pt[COL];
  end else begin : g_bias
    assign coord = ONE;
  end

  assign wr = word_i.valid && (word_i.req_type == REQ_LOAD) &&
              (word_i.element_index[3:2] == 2'(COL)) &&
              (word_i.element_index[1:0] != ROW_UNUSED);

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      prod_d[r] = PROD_W'($signed(col_q[r])) * PROD_W'($signed(coord));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
      for (int r = 0; r < ROWS; r++) begin
        col_q[r]  <= (r == COL) ? ONE : '0;
        prod_q[r] <= '0;
      end
    end else if (en_i) begin
      w_q <= word_i;
      for (int r = 0; r < ROWS; r++) begin
        prod_q[r] <= prod_d[r];
      end
      if (wr) begin
        col_q[word_i.element_index[1:0]] <= word_i.element_value;
      end
    end
  end

  always_comb begin
    word_o = w_q;
    for (int r = 0; r < ROWS; r++) begin
      word_o.acc[r] = $signed(w_q.acc[r]) + ACC_W'(prod_q[r]);
    end
  end

`ifndef NO_ASSERTIONS
  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(w_q))
    else $error("cell word moved while chain held");

  a_col_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(en_i && wr) |=> $stable(col_q))
    else $error("matrix column changed without a load");

  a_col_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && wr) |=>
      col_q[$past(word_i.element_index[1:0])] == $past(word_i.element_value))
    else $error("matrix load did not land");
`endif

endmodule

`default_nettype wire

/* rtl/apt_out_stage.sv */
`default_nettype none

module apt_out_stage import apt_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire word_t        word_i,
  output logic              out_valid_o,
  output logic [DATA_W-1:0] out_x_o,
  output logic [DATA_W-1:0] out_y_o,
  output logic [DATA_W-1:0] out_z_o,
  output logic              saturated_o
);

  logic                        out_valid_q;
  logic [ROWS-1:0][DATA_W-1:0] res_q, res_d;
  logic                        sat_q, sat_d;
  logic                        take;

  always_comb begin
    logic signed [ACC_W-1:0] sh;
    logic [ACC_W-DATA_W:0]   hi;
    sat_d = 1'b0;
    for (int r = 0; r < ROWS; r++) begin
      sh = $signed(word_i.acc[r]) >>> FRAC_BITS;
      hi = sh[ACC_W-1:DATA_W-1];
      if ((&hi) || !(|hi)) begin
        res_d[r] = sh[DATA_W-1:0];
      end else begin
        sat_d    = 1'b1;
        res_d[r] = sh[ACC_W-1] ? SAT_MIN : SAT_MAX;
      end
    end
  end

  assign take = word_i.valid && (word_i.req_type == REQ_XFORM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      res_q       <= '0;
      sat_q       <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= take;
      res_q       <= res_d;
      sat_q       <= sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = res_q[0];
  assign out_y_o     = res_q[1];
  assign out_z_o     = res_q[2];
  assign saturated_o = sat_q;

`ifndef NO_ASSERTIONS
  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(en_i && take))
    else $error("result appeared without a transform word");

  a_no_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && !take) |=> !out_valid_q)
    else $error("load or bubble produced a result");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en_i && out_valid_q) |=> out_valid_q)
    else $error("held result dropped");
`endif

endmodule

`default_nettype wire

/* rtl/affine_point_transform_unit.sv */
// channel  direction  handshake               payload
// in       input      in_valid_i / in_stall_o  req_type, element_index, element_value, point_x/y/z
// out      output     out_valid_o / out_stall_i out_x, out_y, out_z, saturated
//
// one word per cycle in/out unless stalled; a transform result is offered from the output register
// the four column cells each do one multiply set and add it in; the output stage shifts, saturates
// reset loads the identity matrix into the cells and empties the chain
// a held result stalls the whole chain; input is taken while the output register drains
`default_nettype none

module affine_point_transform_unit import apt_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     req_type_i,
  input  wire logic [IDX_W-1:0]         element_index_i,
  input  wire logic signed [DATA_W-1:0] element_value_i,
  input  wire logic signed [DATA_W-1:0] point_x_i,
  input  wire logic signed [DATA_W-1:0] point_y_i,
  input  wire logic signed [DATA_W-1:0] point_z_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [DATA_W-1:0]      out_x_o,
  output logic signed [DATA_W-1:0]      out_y_o,
  output logic signed [DATA_W-1:0]      out_z_o,
  output logic                          saturated_o
);

  word_t chain [CELLS+1];
  word_t in_word;
  logic  en;

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  always_comb begin
    in_word               = '0;
    in_word.valid         = in_valid_i;
    in_word.req_type      = req_type_i;
    in_word.element_index = element_index_i;
    in_word.element_value = element_value_i;
    in_word.pt[0]         = point_x_i;
    in_word.pt[1]         = point_y_i;
    in_word.pt[2]         = point_z_i;
  end

  assign chain[0] = in_word;

  for (genvar c = 0; c < CELLS; c++) begin : g_cell
    apt_cell #(
      .COL       (c),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .word_i (chain[c]),
      .word_o (chain[c+1])
    );
  end

  apt_out_stage #(
    .FRAC_BITS (FRAC_BITS)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .word_i      (chain[CELLS]),
    .out_valid_o (out_valid_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .saturated_o (saturated_o)
  );

endmodule

`default_nettype wire
